/* rtl/stg_pkg.sv */
// stg_pkg: shared types and constants for the stepper tone generator.
// No dependencies; imported by stg_cell and stepper_tone_generator_core.
package stg_pkg;

    localparam int REQ_W    = 3;
    localparam int CHAN_W   = 3;
    localparam int NOTE_W   = 7;
    localparam int HALF_W   = 16;
    localparam int HEAD_W   = 8;
    localparam int LEVELS_W = 8;

    localparam logic [HEAD_W-1:0] HEAD_MAX_RESET = 8'd150;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK     = 3'd0,
        REQ_NOTE_ON  = 3'd1,
        REQ_NOTE_OFF = 3'd2,
        REQ_PERIOD   = 3'd3,
        REQ_STOP_ALL = 3'd4
    } req_code_t;

    // Request word carried from cell to cell along the chain.
    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [CHAN_W-1:0] chan_index;
        logic [NOTE_W-1:0] note_number;
        logic              any_active;
    } req_t;

endpackage

/* rtl/stg_cell.sv */
// stg_cell: one channel of the tone generator, one link of the request chain.
// Depends on stg_pkg for the request word and request codes.
module stg_cell
    import stg_pkg::*;
#(
    parameter int CELL_IDX    = 0,
    parameter int PERIOD_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [HEAD_W-1:0]      max_head_pos,
    input  logic                   tok_in,
    input  req_t                   req_in,
    input  logic [PERIOD_BITS-1:0] per_in,
    output logic                   tok_out,
    output req_t                   req_out,
    output logic [PERIOD_BITS-1:0] per_out,
    output logic                   step_o,
    output logic                   dir_o,
    output logic                   active_o
);

    logic [NOTE_W-1:0]      note_reg, note_next;
    logic                   active_reg, active_next;
    logic [PERIOD_BITS-1:0] period_reg, period_next;
    logic [PERIOD_BITS-1:0] count_reg, count_next;
    logic                   step_reg, step_next;
    logic                   dir_reg, dir_next;
    logic [HEAD_W-1:0]      head_reg, head_next;
    logic [HEAD_W-1:0]      head_move;
    logic                   hit;

    logic                   tok_reg;
    req_t                   req_reg;
    logic [PERIOD_BITS-1:0] per_reg;

    always_comb begin
        note_next   = note_reg;
        active_next = active_reg;
        period_next = period_reg;
        count_next  = count_reg;
        step_next   = step_reg;
        dir_next    = dir_reg;
        head_next   = head_reg;
        head_move   = dir_reg ? (head_reg - HEAD_W'(1)) : (head_reg + HEAD_W'(1));
        hit         = (int'(req_in.chan_index) == CELL_IDX);
        if (tok_in) begin
            case (req_in.req_type)
                REQ_TICK: begin
                    if (req_in.any_active && (period_reg != '0)) begin
                        if (count_reg >= period_reg) begin
                            head_next  = head_move;
                            if ((head_move == max_head_pos) || (head_move == '0)) begin
                                dir_next = ~dir_reg;
                            end
                            step_next  = ~step_reg;
                            count_next = '0;
                        end else begin
                            count_next = count_reg + PERIOD_BITS'(1);
                        end
                    end
                end
                REQ_NOTE_ON: begin
                    if (hit) begin
                        note_next   = req_in.note_number;
                        period_next = per_in;
                        active_next = 1'b1;
                    end
                end
                REQ_NOTE_OFF: begin
                    if (hit && (note_reg == req_in.note_number)) begin
                        note_next   = '0;
                        period_next = '0;
                        active_next = 1'b0;
                        step_next   = 1'b0;
                    end
                end
                REQ_PERIOD: begin
                    if (hit && active_reg) begin
                        period_next = per_in;
                    end
                end
                REQ_STOP_ALL: begin
                    note_next   = '0;
                    active_next = 1'b0;
                    period_next = '0;
                    count_next  = '0;
                    step_next   = 1'b0;
                    dir_next    = 1'b0;
                    head_next   = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            note_reg   <= '0;
            active_reg <= 1'b0;
            period_reg <= '0;
            count_reg  <= '0;
            step_reg   <= 1'b0;
            dir_reg    <= 1'b0;
            head_reg   <= '0;
            tok_reg    <= 1'b0;
        end else begin
            note_reg   <= note_next;
            active_reg <= active_next;
            period_reg <= period_next;
            count_reg  <= count_next;
            step_reg   <= step_next;
            dir_reg    <= dir_next;
            head_reg   <= head_next;
            tok_reg    <= tok_in;
        end
    end

    // Request payload to the neighbor; only meaningful with the token.
    always_ff @(posedge aclk) begin
        req_reg <= req_in;
        per_reg <= per_in;
    end

    assign tok_out  = tok_reg;
    assign req_out  = req_reg;
    assign per_out  = per_reg;
    assign step_o   = step_reg;
    assign dir_o    = dir_reg;
    assign active_o = active_reg;

endmodule

/* rtl/stepper_tone_generator_core.sv */
// stepper_tone_generator_core: top level of the multi-channel step tone generator.
// Depends on stg_pkg and on stg_cell (one cell per channel, chained).
//
//  channel   direction  handshake          word contents
//  s_*       in         s_valid/s_ready    req_type, chan_index, note_number, half_period
//  m_*       out        m_valid/m_ready    step_levels, dir_levels, active_mask
//  cfg_*     in         cfg_wr_en          max_head_pos (cfg_wr_data)
//
// Order: a word visits cell 0 at the accept edge and then each following cell in turn,
// through the chain registers; a result is ready once the token leaves the last cell,
// and no new word is taken until that result loads into the output register.
// Reset: aresetn low at a clock edge clears every channel, the chain tokens and the
// output valid flag, and loads max_head_pos with 150. No clearing pass follows.
// Stalls: a finished word waits in the output register; the next input word is
// accepted meanwhile. A result that finds the output register full holds in the cells.
module stepper_tone_generator_core
    import stg_pkg::*;
#(
    parameter int NUM_CHANNELS = 8,
    parameter int PERIOD_BITS  = 16
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_wr_en,
    input  logic [HEAD_W-1:0]   cfg_wr_data,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [REQ_W-1:0]    s_req_type,
    input  logic [CHAN_W-1:0]   s_chan_index,
    input  logic [NOTE_W-1:0]   s_note_number,
    input  logic [HALF_W-1:0]   s_half_period,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [LEVELS_W-1:0] m_step_levels,
    output logic [LEVELS_W-1:0] m_dir_levels,
    output logic [LEVELS_W-1:0] m_active_mask
);

    logic [HEAD_W-1:0] max_head_reg;

    // Control: busy from accept until the result lands in the output register.
    logic busy_reg, busy_next;
    logic pending_reg, pending_next;
    logic m_valid_reg, m_valid_next;
    logic s_accept;
    logic result_ready;
    logic load;

    logic [LEVELS_W-1:0] step_out_reg, dir_out_reg, active_out_reg;
    logic [LEVELS_W-1:0] step_view, dir_view, active_view;

    // Chain links: index i is what cell i hands to cell i+1.
    logic [NUM_CHANNELS-1:0]   tok_vec;
    req_t                      req_vec [NUM_CHANNELS];
    logic [PERIOD_BITS-1:0]    per_vec [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]   step_vec, dir_vec, active_vec;

    req_t                      req_head;
    logic [PERIOD_BITS-1:0]    per_head;
    logic [HALF_W+PERIOD_BITS-1:0] per_ext;

    assign s_ready  = !busy_reg;
    assign s_accept = s_valid && s_ready;

    // Fit the half period to the stored period width: zero-extend or truncate.
    assign per_ext  = {{PERIOD_BITS{1'b0}}, s_half_period};
    assign per_head = per_ext[PERIOD_BITS-1:0];

    // Sample "any channel active" at accept; no event that needs it changes it.
    always_comb begin
        req_head.req_type    = s_req_type;
        req_head.chan_index  = s_chan_index;
        req_head.note_number = s_note_number;
        req_head.any_active  = |active_vec;
    end

    genvar gi;
    generate
        for (gi = 0; gi < NUM_CHANNELS; gi++) begin : g_cell
            logic                   tok_in;
            req_t                   req_in;
            logic [PERIOD_BITS-1:0] per_in;
            if (gi == 0) begin : g_first
                assign tok_in = s_accept;
                assign req_in = req_head;
                assign per_in = per_head;
            end else begin : g_link
                assign tok_in = tok_vec[gi-1];
                assign req_in = req_vec[gi-1];
                assign per_in = per_vec[gi-1];
            end
            stg_cell #(
                .CELL_IDX    (gi),
                .PERIOD_BITS (PERIOD_BITS)
            ) u_cell (
                .aclk         (aclk),
                .aresetn      (aresetn),
                .max_head_pos (max_head_reg),
                .tok_in       (tok_in),
                .req_in       (req_in),
                .per_in       (per_in),
                .tok_out      (tok_vec[gi]),
                .req_out      (req_vec[gi]),
                .per_out      (per_vec[gi]),
                .step_o       (step_vec[gi]),
                .dir_o        (dir_vec[gi]),
                .active_o     (active_vec[gi])
            );
        end

        // Only the first eight channels show in the result; missing ones read 0.
        for (gi = 0; gi < LEVELS_W; gi++) begin : g_view
            if (gi < NUM_CHANNELS) begin : g_have
                assign step_view[gi]   = step_vec[gi];
                assign dir_view[gi]    = dir_vec[gi];
                assign active_view[gi] = active_vec[gi];
            end else begin : g_none
                assign step_view[gi]   = 1'b0;
                assign dir_view[gi]    = 1'b0;
                assign active_view[gi] = 1'b0;
            end
        end
    endgenerate

    // The token leaving the last cell means every channel has taken the word.
    assign result_ready = tok_vec[NUM_CHANNELS-1] || pending_reg;
    assign load         = result_ready && (!m_valid_reg || m_ready);

    always_comb begin
        busy_next    = busy_reg;
        pending_next = result_ready && !load;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load) begin
            m_valid_next = 1'b1;
            busy_next    = 1'b0;
        end
        if (s_accept) begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            pending_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            max_head_reg <= HEAD_MAX_RESET;
        end else begin
            busy_reg    <= busy_next;
            pending_reg <= pending_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                max_head_reg <= cfg_wr_data;
            end
        end
    end

    // Capture the channel levels; cells hold still while a result is pending.
    always_ff @(posedge aclk) begin
        if (load) begin
            step_out_reg   <= step_view;
            dir_out_reg    <= dir_view;
            active_out_reg <= active_view;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_step_levels = step_out_reg;
    assign m_dir_levels  = dir_out_reg;
    assign m_active_mask = active_out_reg;

`ifndef SYNTH
    // At most one word walks the chain.
    assert property (@(posedge aclk) disable iff (!aresetn) $onehot0(tok_vec))
        else $error("more than one token in the cell chain");

    // An idle block has no token in flight and nothing pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> ((tok_vec == '0) && !pending_reg))
        else $error("token or pending result while idle");

    // A result is held back only while the output register is occupied.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg |-> m_valid_reg)
        else $error("pending result with free output register");

    // A loaded result frees the input side at the next edge.
    assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (m_valid_reg && s_ready))
        else $error("load did not present a result and reopen input");
`endif

endmodule

/* tb/tb_stepper_tone_generator_core.sv */
`timescale 1ns / 1ps
// Self-checking testbench for stepper_tone_generator_core: predicts the channel levels
// for every request word and checks each result word in order. Depends on stg_pkg.
module tb_stepper_tone_generator_core;
    import stg_pkg::*;

    localparam int NUM_CHAN = 8;
    localparam int CYCLE_LIMIT = 400000;
    // Settle time after the last result: scales with the number of channel cells, plus margin.
    localparam int SETTLE_CYCLES = NUM_CHAN + 6;

    localparam logic [HEAD_W-1:0] HEAD_LIMIT_MIN = 8'd1;
    localparam logic [HEAD_W-1:0] HEAD_LIMIT_MAX = 8'd255;
    localparam logic [HEAD_W-1:0] HEAD_LIMIT_TIGHT = 8'd7;

    // Request codes the block must pass through without a state change.
    localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNUSED_MID = 3'd6;
    localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [LEVELS_W-1:0] step_levels;
        logic [LEVELS_W-1:0] dir_levels;
        logic [LEVELS_W-1:0] active_mask;
    } levels_t;

    // Channel model plus the queue of level words still owed by the block.
    class channel_level_board;
        logic [NOTE_W-1:0] note_mem [NUM_CHAN];
        logic              active [NUM_CHAN];
        logic [HALF_W-1:0] period_mem [NUM_CHAN];
        logic [HALF_W-1:0] count_mem [NUM_CHAN];
        logic              step [NUM_CHAN];
        logic              dir [NUM_CHAN];
        logic [HEAD_W-1:0] head [NUM_CHAN];
        logic [HEAD_W-1:0] head_limit;
        levels_t           level_queue [$];
        int unsigned       word_count;
        int unsigned       errors;

        function new();
            head_limit = HEAD_MAX_RESET;
            word_count = 0;
            errors = 0;
            clear_channels();
        endfunction

        function void clear_channels();
            for (int c = 0; c < NUM_CHAN; c++) begin
                note_mem[c] = '0;
                active[c] = 1'b0;
                period_mem[c] = '0;
                count_mem[c] = '0;
                step[c] = 1'b0;
                dir[c] = 1'b0;
                head[c] = '0;
            end
        endfunction

        function void set_head_limit(logic [HEAD_W-1:0] value);
            head_limit = value;
        endfunction

        function logic [NOTE_W-1:0] held_note(logic [CHAN_W-1:0] ch);
            return note_mem[ch];
        endfunction

        function int pending();
            return level_queue.size();
        endfunction

        // One tick: only runs when some channel holds a note; silent channels stay put.
        function void advance_channels();
            bit any_on;
            any_on = 1'b0;
            for (int c = 0; c < NUM_CHAN; c++)
                if (active[c]) any_on = 1'b1;
            if (!any_on) return;
            for (int c = 0; c < NUM_CHAN; c++) begin
                if (period_mem[c] == '0) continue;
                if (count_mem[c] >= period_mem[c]) begin
                    // Move the head (wraps mod 256), flip at either end, toggle step.
                    if (dir[c]) head[c] = head[c] - 1'b1;
                    else head[c] = head[c] + 1'b1;
                    if (head[c] == head_limit || head[c] == '0) dir[c] = ~dir[c];
                    step[c] = ~step[c];
                    count_mem[c] = '0;
                end else begin
                    count_mem[c] = count_mem[c] + 1'b1;
                end
            end
        endfunction

        // Apply one accepted request word and queue the levels it must produce.
        function void note_word(logic [REQ_W-1:0] req, logic [CHAN_W-1:0] ch,
                                logic [NOTE_W-1:0] note, logic [HALF_W-1:0] half);
            levels_t lv;
            case (req)
                REQ_TICK: advance_channels();
                REQ_NOTE_ON: begin
                    note_mem[ch] = note;
                    period_mem[ch] = half;
                    active[ch] = 1'b1;
                end
                REQ_NOTE_OFF: begin
                    if (note_mem[ch] == note) begin
                        note_mem[ch] = '0;
                        period_mem[ch] = '0;
                        active[ch] = 1'b0;
                        step[ch] = 1'b0;
                    end
                end
                REQ_PERIOD: if (active[ch]) period_mem[ch] = half;
                REQ_STOP_ALL: clear_channels();
                default: ;
            endcase
            lv = '0;
            for (int c = 0; c < NUM_CHAN; c++) begin
                lv.step_levels[c] = step[c];
                lv.dir_levels[c] = dir[c];
                lv.active_mask[c] = active[c];
            end
            level_queue.push_back(lv);
        endfunction

        function void report_mismatch(string msg);
            $display("[tb] mismatch: %s", msg);
            errors++;
        endfunction

        function void compare_field(string field, logic [LEVELS_W-1:0] got,
                                    logic [LEVELS_W-1:0] want);
            if (got !== want)
                report_mismatch($sformatf("word %0d %s got %02h expected %02h",
                                          word_count, field, got, want));
        endfunction

        function void check_word(logic [LEVELS_W-1:0] st, logic [LEVELS_W-1:0] dr,
                                 logic [LEVELS_W-1:0] ac);
            levels_t want;
            word_count++;
            if (level_queue.size() == 0) begin
                report_mismatch($sformatf("word %0d arrived with nothing expected",
                                          word_count));
                return;
            end
            want = level_queue.pop_front();
            compare_field("step_levels", st, want.step_levels);
            compare_field("dir_levels", dr, want.dir_levels);
            compare_field("active_mask", ac, want.active_mask);
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [HEAD_W-1:0]   cfg_wr_data;
    logic                s_valid;
    logic                s_ready;
    logic [REQ_W-1:0]    s_req_type;
    logic [CHAN_W-1:0]   s_chan_index;
    logic [NOTE_W-1:0]   s_note_number;
    logic [HALF_W-1:0]   s_half_period;
    logic                m_valid;
    logic                m_ready;
    logic [LEVELS_W-1:0] m_step_levels;
    logic [LEVELS_W-1:0] m_dir_levels;
    logic [LEVELS_W-1:0] m_active_mask;

    channel_level_board board;
    bit                 steady;       // high while neither side may idle
    int unsigned        cycle_count;

    stepper_tone_generator_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_chan_index  (s_chan_index),
        .s_note_number (s_note_number),
        .s_half_period (s_half_period),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_step_levels (m_step_levels),
        .m_dir_levels  (m_dir_levels),
        .m_active_mask (m_active_mask)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Receiver: stall about 8 percent of the time, never inside the steady stretch.
    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 8);
    end

    // Sample the result channel at the rising edge; every handshake is one word.
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1)
            board.check_word(m_step_levels, m_dir_levels, m_active_mask);
    end

    // Hard stop if the block hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[stepper_tone_generator_core] ERROR");
            $finish;
        end
    end

    // Present one request word at the falling edge, optionally after an idle gap,
    // and hold it until the block takes it. Valid stays high on return, so the
    // caller must either send again or drop valid at the very next falling edge.
    task automatic send_word(input logic [REQ_W-1:0] req, input logic [CHAN_W-1:0] ch,
                             input logic [NOTE_W-1:0] note, input logic [HALF_W-1:0] half);
        @(negedge aclk);
        if (!steady && $urandom_range(0, 99) < 8) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_req_type = req;
        s_chan_index = ch;
        s_note_number = note;
        s_half_period = half;
        do @(posedge aclk); while (s_ready !== 1'b1);
        board.note_word(req, ch, note, half);
    endtask

    // Drop valid, wait for every owed word, then let the cell chain settle.
    task automatic drain_results();
        @(negedge aclk);
        s_valid = 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write max_head_pos; only called with the block idle.
    task automatic write_head_limit(input logic [HEAD_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = value;
        @(posedge aclk);
        board.set_head_limit(value);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Mostly short periods so heads travel; sometimes the full 16-bit range.
    function automatic logic [HALF_W-1:0] pick_period();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return HALF_W'($urandom_range(0, 3));
        if (r < 9) return HALF_W'($urandom_range(4, 40));
        return HALF_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [REQ_W-1:0] REQ_TYPE_UNUSED();
        return REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
    endfunction

    // One random word: tick_pct percent ticks, stop_pct percent stop-all, the rest note traffic
    // and the occasional unused request code, with most note-offs hitting the held note.
    task automatic send_random(input int tick_pct, input int stop_pct);
        int                pick;
        logic [CHAN_W-1:0] ch;
        logic [NOTE_W-1:0] note;
        logic [HALF_W-1:0] half;
        pick = $urandom_range(0, 99);
        ch = CHAN_W'($urandom_range(0, NUM_CHAN - 1));
        note = NOTE_W'($urandom_range(0, 127));
        half = HALF_W'($urandom_range(0, 65535));
        if (pick < tick_pct) begin
            send_word(REQ_TICK, ch, note, half);
        end else if (pick < tick_pct + stop_pct) begin
            send_word(REQ_STOP_ALL, ch, note, half);
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: send_word(REQ_NOTE_ON, ch, note, pick_period());
                4, 5, 6: send_word(REQ_NOTE_OFF, ch,
                                   ($urandom_range(0, 3) != 0) ? board.held_note(ch) : note,
                                   half);
                7, 8: send_word(REQ_PERIOD, ch, note, pick_period());
                default: send_word(REQ_TYPE_UNUSED(), ch, note, half);
            endcase
        end
    endtask

    initial begin
        board = new();
        steady = 1'b0;
        cycle_count = 0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_req_type = REQ_TICK;
        s_chan_index = '0;
        s_note_number = '0;
        s_half_period = '0;
        m_ready = 1'b0;

        // Hold reset, then release it at a falling edge.
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed words, max_head_pos still at its reset value.
        send_word(REQ_TICK, 3'd0, 7'd0, 16'd0);               // tick with nothing active
        send_word(REQ_NOTE_OFF, 3'd3, 7'd0, 16'd0);           // note 0 off on an idle channel
        send_word(REQ_PERIOD, 3'd2, 7'd0, 16'hFFFF);          // period update on idle: dropped
        send_word(REQ_NOTE_ON, 3'd0, 7'd127, 16'd0);          // active but silent
        send_word(REQ_NOTE_ON, 3'd7, 7'd0, 16'd1);
        send_word(REQ_NOTE_ON, 3'd1, 7'd60, 16'hFFFF);
        send_word(REQ_NOTE_ON, 3'd2, 7'd64, 16'd2);
        send_word(REQ_TICK, 3'd7, 7'd127, 16'hFFFF);
        send_word(REQ_TICK, 3'd0, 7'd0, 16'd0);
        send_word(REQ_TICK, 3'd5, 7'd42, 16'h5A5A);
        send_word(REQ_TICK, 3'd2, 7'd85, 16'hA5A5);
        send_word(REQ_PERIOD, 3'd1, 7'd0, 16'd1);             // counter now above period
        send_word(REQ_TICK, 3'd0, 7'd0, 16'd0);
        send_word(REQ_NOTE_OFF, 3'd1, 7'd61, 16'd0);          // wrong note: ignored
        send_word(REQ_NOTE_OFF, 3'd1, 7'd60, 16'd0);          // matching note: step forced low
        send_word(REQ_PERIOD, 3'd1, 7'd0, 16'd3);             // channel gone idle: dropped
        send_word(REQ_UNUSED_LO, 3'd7, 7'd127, 16'hFFFF);
        send_word(REQ_UNUSED_MID, 3'd2, 7'd64, 16'd0);
        send_word(REQ_UNUSED_HI, 3'd0, 7'd0, 16'd1);
        send_word(REQ_TICK, 3'd0, 7'd0, 16'd0);
        send_word(REQ_NOTE_OFF, 3'd7, 7'd0, 16'd0);
        send_word(REQ_STOP_ALL, 3'd4, 7'd1, 16'd9);
        send_word(REQ_TICK, 3'd0, 7'd0, 16'd0);               // everything cleared again
        drain_results();

        // Tightest head range: heads bounce between 0 and 1.
        write_head_limit(HEAD_LIMIT_MIN);
        repeat (125) send_random(50, 2);
        // Hold off the sender until every owed word is back, then carry on.
        drain_results();
        repeat (125) send_random(50, 2);
        drain_results();

        // Widest range: start every channel fast, then mostly ticks so the heads
        // climb far; the first part runs with no idling on either side.
        write_head_limit(HEAD_LIMIT_MAX);
        for (int c = 0; c < NUM_CHAN; c++)
            send_word(REQ_NOTE_ON, CHAN_W'(c), NOTE_W'($urandom_range(0, 127)),
                      HALF_W'($urandom_range(1, 2)));
        steady = 1'b1;
        repeat (300) send_random(95, 0);
        steady = 1'b0;
        repeat (260) send_random(95, 0);
        drain_results();

        // Shrink the range with heads still far out: they wrap through 255 to 0.
        write_head_limit(HEAD_LIMIT_MAX - HEAD_LIMIT_MAX / 2 -
                         HEAD_W'($urandom_range(0, 60)));
        repeat (300) send_random(75, 0);
        drain_results();

        write_head_limit(HEAD_LIMIT_TIGHT);
        repeat (200) send_random(50, 3);
        drain_results();

        if (board.errors == 0 && board.pending() == 0) begin
            $display("[stepper_tone_generator_core] OK");
        end else begin
            $display("[stepper_tone_generator_core] ERROR");
        end
        $finish;
    end

endmodule

/* stepper_tone_generator_core.f */
rtl/stg_pkg.sv
rtl/stg_cell.sv
rtl/stepper_tone_generator_core.sv
tb/tb_stepper_tone_generator_core.sv
